/* hw/rtl/cct_pkg.sv */
// Shared types and constants for the configuration text tokenizer.
package cct_pkg;

    localparam int TEXT_BUFFER = 64;
    localparam int TEXT_CAP    = TEXT_BUFFER - 1;
    localparam int CNT_W       = $clog2(TEXT_BUFFER);
    localparam int RES_MAX     = 4;
    localparam int RES_CNT_W   = $clog2(RES_MAX + 1);
    localparam int RES_IDX_W   = $clog2(RES_MAX);

    localparam logic [7:0]  COMMENT_RESET = 8'd35;
    localparam logic [30:0] NUM_LIMIT     = 31'h7FFF_FFFF;
    localparam logic [15:0] LINE_MAX      = 16'hFFFF;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_WORD    = 4'd1,
        M_QUOTE   = 4'd2,
        M_DEC     = 4'd3,
        M_ZERO    = 4'd4,
        M_ZERO_LX = 4'd5,
        M_ZERO_UX = 4'd6,
        M_OCT     = 4'd7,
        M_HEX     = 4'd8,
        M_HALT    = 4'd9,
        M_DONE    = 4'd10
    } lex_mode_t;

    typedef enum logic [2:0] {
        TOK_TEXT    = 3'd0,
        TOK_IDEND   = 3'd1,
        TOK_STREND  = 3'd2,
        TOK_NUMERIC = 3'd3,
        TOK_PUNCT   = 3'd4,
        TOK_STRAY   = 3'd5,
        TOK_END     = 3'd6,
        TOK_ERROR   = 3'd7
    } tok_kind_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
    } in_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [7:0]  char_out;
        logic [30:0] number_value;
        logic [5:0]  text_length;
        logic [15:0] line_number;
        logic        last_result;
    } out_t;

    typedef struct packed {
        lex_mode_t        mode;
        logic             in_quote;
        logic             in_comment;
        logic             prev_bs;
        logic [CNT_W-1:0] text_count;
        logic [30:0]      accum;
        logic             overflow;
        logic [15:0]      line;
    } lex_state_t;

    localparam lex_state_t LEX_CLEAR = '{
        mode: M_IDLE, in_quote: 1'b0, in_comment: 1'b0, prev_bs: 1'b0,
        text_count: '0, accum: '0, overflow: 1'b0, line: 16'd1
    };

endpackage

/* hw/rtl/cct_lexer.sv */
// Combinational comment filter and lexer step for one input beat.
module cct_lexer (
    input  cct_pkg::in_t                          item,
    input  cct_pkg::lex_state_t                   st_cur,
    input  logic [7:0]                            comment_char,
    output cct_pkg::lex_state_t                   st_next,
    output cct_pkg::out_t [cct_pkg::RES_MAX-1:0]  res,
    output logic [cct_pkg::RES_CNT_W-1:0]         res_count
);

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_QUOTE = 8'd34;
    localparam logic [7:0] CH_BSL   = 8'd92;
    localparam logic [7:0] CH_UNDER = 8'd95;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_LX    = 8'd120;
    localparam logic [7:0] CH_UX    = 8'd88;
    // A character can be handed back twice over the passes, so three passes cover it.
    localparam int PASSES = 3;

    typedef struct packed {
        cct_pkg::lex_state_t st;
        cct_pkg::out_t       e0;
        cct_pkg::out_t       e1;
        logic [1:0]          ne;
        logic                again;
    } pass_t;

    function automatic logic is_blank(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction

    function automatic logic is_octal(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd55;
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    // Bit 4 flags a valid hex digit, the low nibble is its value.
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] t;
        t = 8'd0;
        if (is_digit(c)) begin
            t = c - 8'd48;
            return {1'b1, t[3:0]};
        end
        if (c >= 8'd97 && c <= 8'd102) begin
            t = c - 8'd87;
            return {1'b1, t[3:0]};
        end
        if (c >= 8'd65 && c <= 8'd70) begin
            t = c - 8'd55;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic cct_pkg::out_t mk(input cct_pkg::tok_kind_t k, input logic [7:0] ch,
                                         input logic [30:0] num,
                                         input logic [cct_pkg::CNT_W-1:0] len,
                                         input logic [15:0] line);
        cct_pkg::out_t o;
        o.token_kind   = k;
        o.char_out     = ch;
        o.number_value = num;
        o.text_length  = 6'(len);
        o.line_number  = line;
        o.last_result  = 1'b0;
        return o;
    endfunction

    function automatic cct_pkg::lex_state_t add_digit(input cct_pkg::lex_state_t s,
                                                      input logic [4:0] base,
                                                      input logic [3:0] d);
        logic [35:0] v;
        cct_pkg::lex_state_t r;
        r = s;
        v = 36'(s.accum) * 36'(base) + 36'(d);
        if (!s.overflow) begin
            if (v > 36'(cct_pkg::NUM_LIMIT)) r.overflow = 1'b1;
            else                             r.accum = v[30:0];
        end
        return r;
    endfunction

    function automatic pass_t finish_number(input pass_t p0, input cct_pkg::lex_state_t s);
        pass_t p;
        p = p0;
        if (s.overflow) begin
            p.e0      = mk(cct_pkg::TOK_ERROR, 8'd0, 31'd0, '0, s.line);
            p.ne      = 2'd1;
            p.st.mode = cct_pkg::M_HALT;
            p.again   = 1'b0;
        end else begin
            p.e0      = mk(cct_pkg::TOK_NUMERIC, 8'd0, s.accum, '0, s.line);
            p.ne      = 2'd1;
            p.st.mode = cct_pkg::M_IDLE;
            p.again   = 1'b1;
        end
        return p;
    endfunction

    function automatic pass_t lex_pass(input cct_pkg::lex_state_t s, input logic [7:0] c);
        pass_t      p;
        logic [4:0] h;
        logic [7:0] dig;
        p.st    = s;
        p.e0    = '0;
        p.e1    = '0;
        p.ne    = 2'd0;
        p.again = 1'b0;
        h       = hex_value(c);
        dig     = c - CH_ZERO;
        unique case (s.mode)
            cct_pkg::M_IDLE: begin
                if (c == CH_NUL) begin
                    p.e0      = mk(cct_pkg::TOK_END, 8'd0, 31'd0, '0, s.line);
                    p.ne      = 2'd1;
                    p.st.mode = cct_pkg::M_DONE;
                end else if (is_blank(c)) begin
                    if (c == CH_LF && s.line != cct_pkg::LINE_MAX) p.st.line = s.line + 16'd1;
                end else if (is_letter(c) || c == CH_UNDER) begin
                    p.e0            = mk(cct_pkg::TOK_TEXT, c, 31'd0, '0, s.line);
                    p.ne            = 2'd1;
                    p.st.text_count = cct_pkg::CNT_W'(1);
                    p.st.mode       = cct_pkg::M_WORD;
                end else if (is_digit(c)) begin
                    p.st.accum    = 31'(dig[3:0]);
                    p.st.overflow = 1'b0;
                    p.st.mode     = (c == CH_ZERO) ? cct_pkg::M_ZERO : cct_pkg::M_DEC;
                end else if (c == CH_QUOTE) begin
                    p.st.text_count = '0;
                    p.st.prev_bs    = 1'b0;
                    p.st.mode       = cct_pkg::M_QUOTE;
                end else if (is_punct(c)) begin
                    p.e0 = mk(cct_pkg::TOK_PUNCT, c, 31'd0, '0, s.line);
                    p.ne = 2'd1;
                end else begin
                    p.e0 = mk(cct_pkg::TOK_STRAY, c, 31'd0, '0, s.line);
                    p.ne = 2'd1;
                end
            end
            cct_pkg::M_WORD: begin
                if ((is_letter(c) || is_digit(c) || c == CH_UNDER) &&
                    s.text_count < cct_pkg::CNT_W'(cct_pkg::TEXT_CAP)) begin
                    p.e0            = mk(cct_pkg::TOK_TEXT, c, 31'd0, '0, s.line);
                    p.ne            = 2'd1;
                    p.st.text_count = s.text_count + cct_pkg::CNT_W'(1);
                end else begin
                    p.e0      = mk(cct_pkg::TOK_IDEND, 8'd0, 31'd0, s.text_count, s.line);
                    p.ne      = 2'd1;
                    p.st.mode = cct_pkg::M_IDLE;
                    p.again   = 1'b1;
                end
            end
            cct_pkg::M_QUOTE: begin
                if (c == CH_NUL) begin
                    p.e0      = mk(cct_pkg::TOK_STREND, 8'd0, 31'd0, s.text_count, s.line);
                    p.ne      = 2'd1;
                    p.st.mode = cct_pkg::M_IDLE;
                    p.again   = 1'b1;
                end else if ((c == CH_QUOTE && !s.prev_bs) ||
                             s.text_count >= cct_pkg::CNT_W'(cct_pkg::TEXT_CAP)) begin
                    p.e0      = mk(cct_pkg::TOK_STREND, 8'd0, 31'd0, s.text_count, s.line);
                    p.ne      = 2'd1;
                    p.st.mode = cct_pkg::M_IDLE;
                end else begin
                    p.e0            = mk(cct_pkg::TOK_TEXT, c, 31'd0, '0, s.line);
                    p.ne            = 2'd1;
                    p.st.text_count = s.text_count + cct_pkg::CNT_W'(1);
                    p.st.prev_bs    = (c == CH_BSL);
                end
            end
            cct_pkg::M_DEC: begin
                if (is_digit(c)) p.st = add_digit(s, 5'd10, dig[3:0]);
                else             p = finish_number(p, s);
            end
            cct_pkg::M_ZERO: begin
                if (c == CH_LX) begin
                    p.st.mode = cct_pkg::M_ZERO_LX;
                end else if (c == CH_UX) begin
                    p.st.mode = cct_pkg::M_ZERO_UX;
                end else if (is_octal(c)) begin
                    p.st      = add_digit(s, 5'd8, dig[3:0]);
                    p.st.mode = cct_pkg::M_OCT;
                end else begin
                    p = finish_number(p, s);
                end
            end
            cct_pkg::M_ZERO_LX, cct_pkg::M_ZERO_UX: begin
                if (h[4]) begin
                    p.st      = add_digit(s, 5'd16, h[3:0]);
                    p.st.mode = cct_pkg::M_HEX;
                end else begin
                    // A bare prefix: number zero, then the x opens an identifier.
                    p.e0 = mk(cct_pkg::TOK_NUMERIC, 8'd0, 31'd0, '0, s.line);
                    p.e1 = mk(cct_pkg::TOK_TEXT,
                              (s.mode == cct_pkg::M_ZERO_LX) ? CH_LX : CH_UX,
                              31'd0, '0, s.line);
                    p.ne            = 2'd2;
                    p.st.text_count = cct_pkg::CNT_W'(1);
                    p.st.mode       = cct_pkg::M_WORD;
                    p.again         = 1'b1;
                end
            end
            cct_pkg::M_OCT: begin
                if (is_octal(c)) p.st = add_digit(s, 5'd8, dig[3:0]);
                else             p = finish_number(p, s);
            end
            cct_pkg::M_HEX: begin
                if (h[4]) p.st = add_digit(s, 5'd16, h[3:0]);
                else      p = finish_number(p, s);
            end
            default: begin
                p.st.mode = cct_pkg::M_IDLE;
                p.again   = 1'b1;
            end
        endcase
        return p;
    endfunction

    always_comb begin
        cct_pkg::lex_state_t         st;
        pass_t                       p;
        logic                        go;
        logic [cct_pkg::RES_CNT_W-1:0] n;
        logic [cct_pkg::RES_CNT_W-1:0] lastn;
        logic [7:0]                  c;
        c  = item.char_code;
        st = st_cur;
        go = 1'b0;
        n  = '0;
        p  = '0;
        for (int i = 0; i < cct_pkg::RES_MAX; i++) res[i] = '0;

        if (item.kind) begin
            st = cct_pkg::LEX_CLEAR;
        end else if (st.mode == cct_pkg::M_HALT || st.mode == cct_pkg::M_DONE) begin
            go = 1'b0;
        end else begin
            go = 1'b1;
            if (c != CH_NUL) begin
                if (st.in_comment) begin
                    if (c != CH_LF) go = 1'b0;
                    else            st.in_comment = 1'b0;
                end else begin
                    if (c == CH_QUOTE) st.in_quote = ~st.in_quote;
                    if (c == comment_char && !st.in_quote && c != CH_LF) begin
                        st.in_comment = 1'b1;
                        go            = 1'b0;
                    end
                end
            end
        end

        for (int k = 0; k < PASSES; k++) begin
            if (go) begin
                p  = lex_pass(st, c);
                st = p.st;
                if (p.ne != 2'd0 && n < cct_pkg::RES_CNT_W'(cct_pkg::RES_MAX)) begin
                    res[n[cct_pkg::RES_IDX_W-1:0]] = p.e0;
                    n = n + cct_pkg::RES_CNT_W'(1);
                end
                if (p.ne == 2'd2 && n < cct_pkg::RES_CNT_W'(cct_pkg::RES_MAX)) begin
                    res[n[cct_pkg::RES_IDX_W-1:0]] = p.e1;
                    n = n + cct_pkg::RES_CNT_W'(1);
                end
                go = p.again;
            end
        end

        lastn = n - cct_pkg::RES_CNT_W'(1);
        if (n != '0) res[lastn[cct_pkg::RES_IDX_W-1:0]].last_result = 1'b1;

        st_next   = st;
        res_count = n;
    end

endmodule

/* hw/rtl/config_text_tokenizer.sv */
// Top level of the configuration text tokenizer: input register, lexer step, result buffer.
// An accepted character beat is held in the input register, and its first token reaches
// m_data once it moves into the result buffer. Throughput: one character per cycle while
// each character yields at most one token and m_ready is high; a character yielding several
// tokens holds the result port while they drain one per beat, and holds s_ready low meanwhile.
// Reset (aresetn low, synchronous): lexer idle, line count 1, buffers empty, comment char '#'.
module config_text_tokenizer (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cct_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output cct_pkg::out_t  m_data,
    input  logic           cfg_we,
    input  logic [7:0]     cfg_wdata
);

    // Input register holding one accepted character beat.
    logic                in_valid_reg;
    cct_pkg::in_t        in_reg;

    // Architectural lexer state and the comment character register.
    cct_pkg::lex_state_t st_reg;
    cct_pkg::lex_state_t st_next;
    logic [7:0]          cc_reg;

    // Result buffer: all tokens of one character, drained one per beat.
    cct_pkg::out_t [cct_pkg::RES_MAX-1:0] buf_reg;
    cct_pkg::out_t [cct_pkg::RES_MAX-1:0] res;
    logic [cct_pkg::RES_CNT_W-1:0]        res_count;
    logic [cct_pkg::RES_CNT_W-1:0]        cnt_reg;
    logic [cct_pkg::RES_IDX_W-1:0]        rd_reg;

    logic pop;
    logic buf_free;
    logic advance;

    cct_lexer u_lexer (
        .item         (in_reg),
        .st_cur       (st_reg),
        .comment_char (cc_reg),
        .st_next      (st_next),
        .res          (res),
        .res_count    (res_count)
    );

    // The buffer can take a new set of tokens when it is empty or its last token
    // leaves in this cycle. The held character moves into the buffer only then,
    // which also commits its state update, so nothing is lost under back-pressure.
    assign m_valid  = (cnt_reg != '0);
    assign m_data   = buf_reg[rd_reg];
    assign pop      = m_valid && m_ready;
    assign buf_free = (cnt_reg == '0) ||
                      (cnt_reg == cct_pkg::RES_CNT_W'(1) && m_ready);
    assign advance  = in_valid_reg && buf_free;

    // A new character can enter while the previous one is moving into the buffer.
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg <= cct_pkg::COMMENT_RESET;
        end else if (cfg_we) begin
            cc_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= cct_pkg::LEX_CLEAR;
        end else if (advance) begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= '0;
        end else if (advance) begin
            cnt_reg <= res_count;
            rd_reg  <= '0;
        end else if (pop) begin
            cnt_reg <= cnt_reg - cct_pkg::RES_CNT_W'(1);
            rd_reg  <= rd_reg + cct_pkg::RES_IDX_W'(1);
        end
    end

    // Token payloads need no reset; the count above qualifies them.
    always_ff @(posedge aclk) begin
        if (advance) begin
            buf_reg <= res;
        end
    end

    // The pending tokens never run past the end of the buffer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cct_pkg::RES_CNT_W'(rd_reg) + cnt_reg) <= cct_pkg::RES_CNT_W'(cct_pkg::RES_MAX))
        else $error("result buffer read position overruns its contents");

    // The token shown alone in the buffer must close its character's group.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == cct_pkg::RES_CNT_W'(1)) |-> m_data.last_result)
        else $error("final buffered token is missing last_result");

    // A restart beat leaves the lexer idle on line one with no tokens.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_reg.kind) |=>
            (st_reg.mode == cct_pkg::M_IDLE && st_reg.line == 16'd1 && cnt_reg == '0))
        else $error("restart did not clear the lexer");

    // After end of input or an error the block produces nothing.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (st_reg.mode == cct_pkg::M_HALT || st_reg.mode == cct_pkg::M_DONE))
            |=> (cnt_reg == '0))
        else $error("tokens produced while halted");

    // A held character waits while the buffer still has more than one token to give.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && cnt_reg > cct_pkg::RES_CNT_W'(1)) |=> $stable(st_reg))
        else $error("lexer state moved while results were pending");

endmodule
